@@ hdl/lxti_pkg.sv @@
// ----------------------------------------------------------------------------
// lxti_pkg
// Types, constants and tables shared by the log-x table interpolator.
// ----------------------------------------------------------------------------
package lxti_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int VAL_W    = 32;
  localparam int PTS_W    = 6;
  localparam int SLOT_W   = 5;
  localparam int LOG_W    = 24;
  localparam int RATIO_W  = 16;
  localparam int CNT_W    = 4;
  localparam int STS_W    = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 6;
  localparam int IN_DAT_W  = 104;

  localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [STS_W-1:0] {
    STS_INTERP   = 3'd0,
    STS_CLAMP_HI = 3'd1,
    STS_CLAMP_LO = 3'd2,
    STS_NONPOS   = 3'd3,
    STS_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_RD_LAST, OP_RD_FIRST, OP_SRCH_INIT, OP_RD_MID, OP_SRCH,
    OP_RD_LO1, OP_RD_LO, OP_LG_START, OP_LG_STEP, OP_LG_SAVE, OP_DIV_START,
    OP_DIV_STEP, OP_LERP, OP_EXP_START, OP_EXP_STEP, OP_RES
  } dp_op_e;

  typedef enum logic [2:0] {
    DST_LLO, DST_LHI, DST_LX, DST_LYLO, DST_LYHI
  } lg_dst_e;

  typedef enum logic [2:0] {
    RES_EMPTY, RES_HIGH, RES_LOW, RES_LERP, RES_NONPOS, RES_EXP
  } res_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] sel;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic n_zero;
    logic ge_last;
    logic le_first;
    logic srch_done;
    logic cnt_last;
    logic div_trivial;
    logic mode;
    logic y_nonpos;
    logic out_full;
  } dp_sts_t;

  typedef logic [31:0] root_tab_t [16];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    x = v;
    for (int i = 31; i >= 0; i--) begin
      b = 64'd1 << (2 * i);
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // 2^(2^-k) in Q2.30, k = 1..16, by chained truncated square roots
  function automatic root_tab_t make_roots();
    root_tab_t  tab;
    logic [63:0] c;
    c = 64'd2 << 30;
    for (int k = 0; k < 16; k++) begin
      c = isqrt64(c << 30);
      tab[k] = c[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t EXP2_ROOT = make_roots();

endpackage

@@ hdl/log_x_table_interpolator_top.sv @@
// A load returns to idle after dispatch; an empty-table or clamped query goes straight to
// the result. An interpolated query adds the binary search, the serial log2 squarer, the
// 16-step divider and, in log mode, the exp2 multiplier. One item is in work at a time.
// Reset (rst_ni low, asynchronous) clears the sequencer, the output valid and both
// configuration registers; the point tables hold no reset value.
// ----------------------------------------------------------------------------
// log_x_table_interpolator_top
// Piecewise table interpolation on a log2 x axis, linear or log y.
// ----------------------------------------------------------------------------
module log_x_table_interpolator_top #(
  parameter int TABLE_DEPTH = lxti_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // point_slot[4:0], point_x[36:5], point_y[68:37], query_x[100:69], zero pad
  input  logic [lxti_pkg::IN_DAT_W-1:0]     s_axis_tdata,
  // cmd[0]
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // result_y[31:0]
  output logic [lxti_pkg::VAL_W-1:0]        m_axis_tdata,
  // status[2:0]
  output logic [lxti_pkg::STS_W-1:0]        m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lxti_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lxti_pkg::CFG_DAT_W-1:0]    cfg_data_i
);
  import lxti_pkg::*;

  cmd_t                    cmd;
  dp_sts_t                 sts;
  logic signed [VAL_W-1:0] out_y;

  assign cfg_ready_o = 1'b1;

  lxti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lxti_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_cmd_i    (s_axis_tuser[0]),
    .in_slot_i   (s_axis_tdata[4:0]),
    .in_px_i     (s_axis_tdata[36:5]),
    .in_py_i     (s_axis_tdata[68:37]),
    .in_qx_i     (s_axis_tdata[100:69]),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_y_o     (out_y),
    .out_sts_o   (m_axis_tuser)
  );

  assign m_axis_tdata = out_y;

endmodule

@@ hdl/lxti_ctrl.sv @@
// ----------------------------------------------------------------------------
// lxti_ctrl
// Sequencer: search, three log evaluations (five in log mode), division, lerp and exp2.
// ----------------------------------------------------------------------------
module lxti_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lxti_pkg::dp_sts_t sts_i,
  output lxti_pkg::cmd_t    cmd_o
);
  import lxti_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISP      = 4'd1;
  localparam logic [3:0] S_CHK_LAST  = 4'd2;
  localparam logic [3:0] S_CHK_FIRST = 4'd3;
  localparam logic [3:0] S_SRCH_RD   = 4'd4;
  localparam logic [3:0] S_SRCH_CMP  = 4'd5;
  localparam logic [3:0] S_LG_START  = 4'd6;
  localparam logic [3:0] S_LG_RUN    = 4'd7;
  localparam logic [3:0] S_LG_SAVE   = 4'd8;
  localparam logic [3:0] S_RD_LO     = 4'd9;
  localparam logic [3:0] S_DIV_START = 4'd10;
  localparam logic [3:0] S_DIV       = 4'd11;
  localparam logic [3:0] S_POST      = 4'd12;
  localparam logic [3:0] S_LERP      = 4'd13;
  localparam logic [3:0] S_EXP       = 4'd14;
  localparam logic [3:0] S_RES       = 4'd15;

  logic [3:0] state_q, state_d;
  lg_dst_e    dst_q, dst_d;
  res_e       res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dst_q   <= DST_LLO;
      res_q   <= RES_EMPTY;
    end else begin
      state_q <= state_d;
      dst_q   <= dst_d;
      res_q   <= res_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    dst_d     = dst_q;
    res_d     = res_q;
    cmd_o.op  = OP_NOP;
    cmd_o.sel = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts_i.is_query) begin
          state_d = S_IDLE;
        end else if (sts_i.n_zero) begin
          res_d   = RES_EMPTY;
          state_d = S_RES;
        end else begin
          cmd_o.op = OP_RD_LAST;
          state_d  = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        if (sts_i.ge_last) begin
          res_d   = RES_HIGH;
          state_d = S_RES;
        end else begin
          cmd_o.op = OP_RD_FIRST;
          state_d  = S_CHK_FIRST;
        end
      end
      S_CHK_FIRST: begin
        if (sts_i.le_first) begin
          res_d   = RES_LOW;
          state_d = S_RES;
        end else begin
          cmd_o.op = OP_SRCH_INIT;
          state_d  = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (sts_i.srch_done) begin
          cmd_o.op = OP_RD_LO1;
          dst_d    = DST_LLO;
          state_d  = S_LG_START;
        end else begin
          cmd_o.op = OP_RD_MID;
          state_d  = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd_o.op = OP_SRCH;
        state_d  = S_SRCH_RD;
      end
      S_LG_START: begin
        cmd_o.op  = OP_LG_START;
        cmd_o.sel = dst_q;
        state_d   = S_LG_RUN;
      end
      S_LG_RUN: begin
        cmd_o.op = OP_LG_STEP;
        if (sts_i.cnt_last) state_d = S_LG_SAVE;
      end
      S_LG_SAVE: begin
        cmd_o.op  = OP_LG_SAVE;
        cmd_o.sel = dst_q;
        unique case (dst_q)
          DST_LLO: state_d = S_RD_LO;
          DST_LHI: begin
            dst_d   = DST_LX;
            state_d = S_LG_START;
          end
          DST_LX:   state_d = S_DIV_START;
          DST_LYLO: begin
            dst_d   = DST_LYHI;
            state_d = S_LG_START;
          end
          DST_LYHI: state_d = S_LERP;
          default:  state_d = S_IDLE;
        endcase
      end
      S_RD_LO: begin
        cmd_o.op = OP_RD_LO;
        dst_d    = DST_LHI;
        state_d  = S_LG_START;
      end
      S_DIV_START: begin
        cmd_o.op = OP_DIV_START;
        state_d  = sts_i.div_trivial ? S_POST : S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (sts_i.cnt_last) state_d = S_POST;
      end
      S_POST: begin
        if (!sts_i.mode) begin
          state_d = S_LERP;
        end else if (sts_i.y_nonpos) begin
          res_d   = RES_NONPOS;
          state_d = S_RES;
        end else begin
          dst_d   = DST_LYLO;
          state_d = S_LG_START;
        end
      end
      S_LERP: begin
        cmd_o.op = OP_LERP;
        if (!sts_i.mode) begin
          res_d   = RES_LERP;
          state_d = S_RES;
        end else begin
          state_d = S_EXP;
        end
      end
      S_EXP: begin
        // first cycle here starts the unit, the counter then runs 16 steps
        if (res_q != RES_EXP) begin
          cmd_o.op = OP_EXP_START;
          res_d    = RES_EXP;
        end else begin
          cmd_o.op = OP_EXP_STEP;
          if (sts_i.cnt_last) state_d = S_RES;
        end
      end
      S_RES: begin
        if (!sts_i.out_full) begin
          cmd_o.op  = OP_RES;
          cmd_o.sel = res_q;
          res_d     = RES_EMPTY;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ hdl/lxti_dp.sv @@
// ----------------------------------------------------------------------------
// lxti_dp
// Datapath: point tables, search registers, log2 squarer, divider, lerp,
// exp2 root multiplier and output register.
// ----------------------------------------------------------------------------
module lxti_dp #(
  parameter int TABLE_DEPTH = lxti_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lxti_pkg::cmd_t                   cmd_i,
  output lxti_pkg::dp_sts_t                sts_o,
  input  logic                             in_cmd_i,
  input  logic [lxti_pkg::SLOT_W-1:0]      in_slot_i,
  input  logic [lxti_pkg::VAL_W-1:0]       in_px_i,
  input  logic signed [lxti_pkg::VAL_W-1:0] in_py_i,
  input  logic [lxti_pkg::VAL_W-1:0]       in_qx_i,
  input  logic                             cfg_we_i,
  input  logic [lxti_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lxti_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [lxti_pkg::VAL_W-1:0] out_y_o,
  output logic [lxti_pkg::STS_W-1:0]       out_sts_o
);
  import lxti_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [VAL_W-1:0] SMAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic [VAL_W-1:0]        x_mem [TABLE_DEPTH];
  logic [VAL_W-1:0]        y_mem [TABLE_DEPTH];

  logic [PTS_W-1:0]        points_q;
  logic                    mode_q;
  logic                    cmd_q;
  logic [VAL_W-1:0]        x_q;
  logic [PTS_W-1:0]        n_q;
  logic [PTS_W-1:0]        lo_q, hi_q;
  logic [VAL_W-1:0]        rd_x_q;
  logic signed [VAL_W-1:0] rd_y_q;
  logic signed [VAL_W-1:0] ylo_q, yhi_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [4:0]              lg_p_q;
  logic [31:0]             lg_m_q;
  logic [15:0]             lg_frac_q;
  logic signed [LOG_W-1:0] la_q, lb_q, lc_q;
  logic [LOG_W-1:0]        rem_q, den_q;
  logic [RATIO_W-1:0]      ratio_q;
  logic signed [VAL_W-1:0] lerp_q;
  logic [31:0]             em_q;
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_y_q;
  logic [STS_W-1:0]        out_sts_q;

  logic [PTS_W:0]          mid_sum;
  logic [PTS_W-1:0]        mid;
  logic [PTS_W-1:0]        n_in;
  logic                    rd_en;
  logic [PTS_W-1:0]        rd_idx;
  logic [VAL_W-1:0]        lg_v;
  logic [4:0]              lg_p;
  logic [63:0]             lg_sq;
  logic [32:0]             lg_t;
  logic [5:0]              lg_pi;
  logic signed [LOG_W-1:0] lg_val;
  logic signed [LOG_W-1:0] num, den;
  logic [LOG_W:0]          rem2;
  logic signed [VAL_W-1:0] la_a, lb_b;
  logic signed [33:0]      as, bs;
  logic                    lneg;
  logic [32:0]             ld;
  logic [48:0]             lprod;
  logic signed [33:0]      lres;
  logic [63:0]             eprod;
  logic signed [17:0]      es;
  logic [17:0]             esh;
  logic [32:0]             em2;
  logic [VAL_W-1:0]        exp_val;
  lg_dst_e                 dst;
  res_e                    rsel;

  assign dst  = lg_dst_e'(cmd_i.sel);
  assign rsel = res_e'(cmd_i.sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q    <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_POINTS: points_q <= cfg_data_i[PTS_W-1:0];
          CFG_MODE:   mode_q   <= cfg_data_i[0];
          default:    ;
        endcase
      end
      if (cmd_i.op == OP_RES) out_valid_q <= 1'b1;
      else if (out_ready_i)   out_valid_q <= 1'b0;
    end
  end

  assign n_in = (int'(points_q) > TABLE_DEPTH) ? PTS_W'(TABLE_DEPTH) : points_q;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid = mid_sum[PTS_W:1];

  always_comb begin
    rd_en  = 1'b1;
    rd_idx = '0;
    unique case (cmd_i.op)
      OP_RD_LAST:  rd_idx = n_q - PTS_W'(1);
      OP_RD_FIRST: rd_idx = '0;
      OP_RD_MID:   rd_idx = mid;
      OP_RD_LO1:   rd_idx = lo_q - PTS_W'(1);
      OP_RD_LO:    rd_idx = lo_q;
      default:     rd_en  = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && in_cmd_i == CMD_LOAD && int'(in_slot_i) < TABLE_DEPTH) begin
      x_mem[AW'(in_slot_i)] <= in_px_i;
      y_mem[AW'(in_slot_i)] <= in_py_i;
    end
    if (rd_en) begin
      rd_x_q <= x_mem[AW'(rd_idx)];
      rd_y_q <= y_mem[AW'(rd_idx)];
    end
  end

  // log2 operand select and leading-one position
  always_comb begin
    unique case (dst)
      DST_LX:   lg_v = x_q;
      DST_LYLO: lg_v = ylo_q;
      DST_LYHI: lg_v = yhi_q;
      default:  lg_v = rd_x_q;
    endcase
    if (lg_v == '0) lg_v = VAL_W'(1);
    lg_p = '0;
    for (int i = 0; i < 32; i++) begin
      if (lg_v[i]) lg_p = 5'(i);
    end
  end

  assign lg_sq  = 64'(lg_m_q) * 64'(lg_m_q);
  assign lg_t   = lg_sq[63:31];
  assign lg_pi  = {1'b0, lg_p_q} - 6'd16;
  assign lg_val = {{(LOG_W-22){lg_pi[5]}}, lg_pi, lg_frac_q};

  assign num  = la_q - lb_q;
  assign den  = lc_q - lb_q;
  assign rem2 = {rem_q, 1'b0};

  // lerp: a + floor(r * (b - a) / 2^16)
  assign la_a  = mode_q ? {{(VAL_W-LOG_W){la_q[LOG_W-1]}}, la_q} : ylo_q;
  assign lb_b  = mode_q ? {{(VAL_W-LOG_W){lc_q[LOG_W-1]}}, lc_q} : yhi_q;
  assign as    = {{2{la_a[VAL_W-1]}}, la_a};
  assign bs    = {{2{lb_b[VAL_W-1]}}, lb_b};
  assign lneg  = (bs < as);
  assign ld    = lneg ? 33'(as - bs) : 33'(bs - as);
  assign lprod = 49'(ratio_q) * 49'(ld);
  assign lres  = lneg ? (as - $signed({1'b0, lprod[48:16]}) - 34'(|lprod[15:0]))
                      : (as + $signed({1'b0, lprod[48:16]}));

  assign eprod = 64'(em_q) * 64'(EXP2_ROOT[cnt_q]);

  always_comb begin
    es      = {{2{lerp_q[VAL_W-1]}}, lerp_q[31:16]} - 18'sd14;
    esh     = 18'(-es);
    em2     = {em_q, 1'b0};
    exp_val = '0;
    if (es >= 18'sd2)       exp_val = SMAX;
    else if (es == 18'sd1)  exp_val = (em2 > 33'(SMAX)) ? SMAX : em2[VAL_W-1:0];
    else if (esh >= 18'd32) exp_val = '0;
    else                    exp_val = em_q >> esh[4:0];
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        cmd_q <= in_cmd_i;
        x_q   <= in_qx_i;
        n_q   <= n_in;
      end
      OP_SRCH_INIT: begin
        lo_q <= '0;
        hi_q <= n_q;
      end
      OP_SRCH: begin
        if (rd_x_q < x_q) lo_q <= mid + PTS_W'(1);
        else              hi_q <= mid;
      end
      OP_LG_START: begin
        if (dst == DST_LLO) ylo_q <= rd_y_q;
        if (dst == DST_LHI) yhi_q <= rd_y_q;
        lg_p_q    <= lg_p;
        lg_m_q    <= lg_v << (5'd31 - lg_p);
        lg_frac_q <= '0;
        cnt_q     <= '0;
      end
      OP_LG_STEP: begin
        if (lg_t[32]) begin
          lg_m_q    <= lg_t[32:1];
          lg_frac_q <= {lg_frac_q[14:0], 1'b1};
        end else begin
          lg_m_q    <= lg_t[31:0];
          lg_frac_q <= {lg_frac_q[14:0], 1'b0};
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
      OP_LG_SAVE: begin
        unique case (dst)
          DST_LLO:  lb_q <= lg_val;
          DST_LHI:  lc_q <= lg_val;
          DST_LYHI: lc_q <= lg_val;
          default:  la_q <= lg_val;
        endcase
      end
      OP_DIV_START: begin
        rem_q   <= num;
        den_q   <= den;
        cnt_q   <= '0;
        if (den <= 0 || num <= 0 || num < den) ratio_q <= '0;
        else                                   ratio_q <= '1;
      end
      OP_DIV_STEP: begin
        if (rem2 >= {1'b0, den_q}) begin
          rem_q   <= LOG_W'(rem2 - {1'b0, den_q});
          ratio_q <= {ratio_q[RATIO_W-2:0], 1'b1};
        end else begin
          rem_q   <= rem2[LOG_W-1:0];
          ratio_q <= {ratio_q[RATIO_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
      OP_LERP: lerp_q <= lres[VAL_W-1:0];
      OP_EXP_START: begin
        em_q  <= 32'd1 << 30;
        cnt_q <= '0;
      end
      OP_EXP_STEP: begin
        if (lerp_q[4'd15 - cnt_q]) em_q <= eprod[61:30];
        cnt_q <= cnt_q + CNT_W'(1);
      end
      OP_RES: begin
        unique case (rsel)
          RES_HIGH: begin
            out_y_q <= rd_y_q;  out_sts_q <= STS_CLAMP_HI;
          end
          RES_LOW: begin
            out_y_q <= rd_y_q;  out_sts_q <= STS_CLAMP_LO;
          end
          RES_LERP: begin
            out_y_q <= lerp_q;  out_sts_q <= STS_INTERP;
          end
          RES_NONPOS: begin
            out_y_q <= '0;      out_sts_q <= STS_NONPOS;
          end
          RES_EXP: begin
            out_y_q <= exp_val; out_sts_q <= STS_INTERP;
          end
          default: begin
            out_y_q <= '0;      out_sts_q <= STS_EMPTY;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign sts_o.is_query    = (cmd_q == CMD_QUERY);
  assign sts_o.n_zero      = (n_q == '0);
  assign sts_o.ge_last     = (rd_x_q <= x_q);
  assign sts_o.le_first    = (x_q <= rd_x_q);
  assign sts_o.srch_done   = (lo_q >= hi_q);
  assign sts_o.cnt_last    = (cnt_q == '1);
  assign sts_o.div_trivial = (den <= 0) || (num <= 0) || (num >= den);
  assign sts_o.mode        = mode_q;
  assign sts_o.y_nonpos    = (ylo_q <= 0) || (yhi_q <= 0);
  assign sts_o.out_full    = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_y_o     = out_y_q;
  assign out_sts_o   = out_sts_q;

endmodule

@@ hdl/lxti_checker.sv @@
// ----------------------------------------------------------------------------
// lxti_checker
// Port-level checks for the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module lxti_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lxti_pkg::VAL_W-1:0]    m_axis_tdata,
  input logic [lxti_pkg::STS_W-1:0]    m_axis_tuser
);
  import lxti_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while previous transaction in work");

  a_zero_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STS_EMPTY || m_axis_tuser == STS_NONPOS))
      |-> (m_axis_tdata == '0))
    else $error("empty or non-positive result not zero");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STS_INTERP || m_axis_tuser == STS_CLAMP_HI ||
      m_axis_tuser == STS_CLAMP_LO || m_axis_tuser == STS_NONPOS ||
      m_axis_tuser == STS_EMPTY))
    else $error("status code out of range");

endmodule

bind log_x_table_interpolator_top lxti_checker u_lxti_checker (.*);
